>>> design/brr_pkg.sv
// Shared types and constants for the BRR block decoder.
// Used by brr_nib_dec and brr_adpcm_block_decoder_core; no dependencies.
package brr_pkg;

    localparam int BYTE_W   = 8;
    localparam int NIB_W    = 4;
    localparam int SAMPLE_W = 15;
    localparam int CALC_W   = 22;

    localparam logic [3:0] SHIFT_MAX = 4'd12;

    localparam logic signed [CALC_W-1:0] LARGE_NEG  = -22'sd4096;
    localparam logic signed [CALC_W-1:0] SAMPLE_MAX = 22'sd32767;
    localparam logic signed [CALC_W-1:0] SAMPLE_MIN = -22'sd32768;

    typedef enum logic [1:0] {
        FILT_NONE = 2'd0,
        FILT_ONE  = 2'd1,
        FILT_TWO  = 2'd2,
        FILT_THREE = 2'd3
    } filt_t;

    // Settings taken from the latest block header byte.
    typedef struct packed {
        logic [3:0] shift;
        filt_t      filter;
        logic       loop_bit;
        logic       end_bit;
    } hdr_t;

endpackage

>>> design/brr_nib_dec.sv
// One-nibble BRR decode: scale by the header shift, apply the prediction
// filter, clamp to 16 bits and wrap to 15 bits. Depends on brr_pkg.
module brr_nib_dec
    import brr_pkg::*;
(
    input  logic [NIB_W-1:0]           nibble,
    input  hdr_t                       hdr,
    input  logic signed [SAMPLE_W-1:0] prev1,
    input  logic signed [SAMPLE_W-1:0] prev2,
    output logic signed [SAMPLE_W-1:0] sample
);

    logic signed [CALC_W-1:0] nib_ext;
    logic signed [CALC_W-1:0] scaled;
    logic signed [CALC_W-1:0] p1;
    logic signed [CALC_W-1:0] p2;
    logic signed [CALC_W-1:0] neg_p1;
    logic signed [CALC_W-1:0] acc;
    logic signed [CALC_W-1:0] clamped;

    always_comb begin
        nib_ext = {{(CALC_W-NIB_W){nibble[NIB_W-1]}}, nibble};
        p1      = {{(CALC_W-SAMPLE_W){prev1[SAMPLE_W-1]}}, prev1};
        p2      = {{(CALC_W-SAMPLE_W){prev2[SAMPLE_W-1]}}, prev2};
        neg_p1  = -p1;

        // shifts above 12 collapse to 0 or -4096
        if (hdr.shift <= SHIFT_MAX) begin
            scaled = (nib_ext <<< hdr.shift) >>> 1;
        end else begin
            scaled = nibble[NIB_W-1] ? LARGE_NEG : '0;
        end

        case (hdr.filter)
            FILT_ONE: begin
                acc = scaled + p1 + (neg_p1 >>> 4);
            end
            FILT_TWO: begin
                acc = scaled + (p1 <<< 1) + (((neg_p1 <<< 1) + neg_p1) >>> 5)
                      - p2 + (p2 >>> 4);
            end
            FILT_THREE: begin
                acc = scaled + (p1 <<< 1)
                      + (((neg_p1 <<< 3) + (neg_p1 <<< 2) + neg_p1) >>> 6)
                      - p2 + (((p2 <<< 1) + p2) >>> 4);
            end
            default: begin
                acc = scaled;
            end
        endcase

        if (acc < SAMPLE_MIN) begin
            clamped = SAMPLE_MIN;
        end else if (acc > SAMPLE_MAX) begin
            clamped = SAMPLE_MAX;
        end else begin
            clamped = acc;
        end

        // keep the low 15 bits only
        sample = clamped[SAMPLE_W-1:0];
    end

endmodule

>>> design/brr_adpcm_block_decoder_core.sv
// BRR ADPCM block decoder, top level.
// Depends on brr_pkg and brr_nib_dec.
//
// Usage:
//   Input channel (s_valid/s_ready) takes one byte of the 9-byte block
//   stream per beat, with s_is_header marking the header byte. A header
//   beat loads shift, filter and end/loop flags and yields no result.
//   A data beat yields two result beats on m_valid/m_ready: the high-nibble
//   sample (m_last = 0), then the low-nibble sample (m_last = 1), each
//   tagged with the end and loop flags of the current header.
//   A data byte's samples pass from the input register through the nibble
//   decoder into the result register; a header beat needs no result slot.
//   The single nibble decoder feeds the result register once per cycle while
//   the result register is free (empty, or its beat taken on m_ready).
//   The input register takes a new beat in the same cycle the held one
//   finishes, and the result register frees itself in the cycle its beat
//   is taken.
//   Reset (aresetn low, synchronous) clears both previous samples, the
//   header settings and all valid flags. When m_ready is low the result
//   holds, data beats stall and s_ready drops once one fills the input register.
module brr_adpcm_block_decoder_core
    import brr_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [BYTE_W-1:0]          s_data_byte,
    input  logic                       s_is_header,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample,
    output logic                       m_last,
    output logic                       m_end_flag,
    output logic                       m_loop_flag
);

    logic                       in_valid_reg;
    logic [BYTE_W-1:0]          in_byte_reg;
    logic                       in_hdr_reg;
    logic                       phase_reg;
    hdr_t                       hdr_reg;
    logic signed [SAMPLE_W-1:0] prev1_reg;
    logic signed [SAMPLE_W-1:0] prev2_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_last_reg;
    logic                       out_end_reg;
    logic                       out_loop_reg;

    logic                       out_free;
    logic                       dec_fire;
    logic                       hdr_fire;
    logic                       in_done;
    logic [NIB_W-1:0]           nib_sel;
    logic signed [SAMPLE_W-1:0] dec_sample;

    assign out_free = !out_valid_reg || m_ready;
    assign dec_fire = in_valid_reg && !in_hdr_reg && out_free;
    assign hdr_fire = in_valid_reg && in_hdr_reg;
    assign in_done  = hdr_fire || (dec_fire && phase_reg);
    assign s_ready  = !in_valid_reg || in_done;
    assign nib_sel  = phase_reg ? in_byte_reg[NIB_W-1:0] : in_byte_reg[BYTE_W-1:NIB_W];

    brr_nib_dec u_nib_dec (
        .nibble (nib_sel),
        .hdr    (hdr_reg),
        .prev1  (prev1_reg),
        .prev2  (prev2_reg),
        .sample (dec_sample)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_data_byte;
                in_hdr_reg   <= s_is_header;
            end else if (in_done) begin
                in_valid_reg <= 1'b0;
            end
            if (dec_fire) begin
                phase_reg <= !phase_reg;
            end
        end
    end

    // decoder state: header settings and sample history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg   <= '0;
            prev1_reg <= '0;
            prev2_reg <= '0;
        end else begin
            if (hdr_fire) begin
                hdr_reg <= hdr_t'(in_byte_reg);
            end
            if (dec_fire) begin
                prev2_reg <= prev1_reg;
                prev1_reg <= dec_sample;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (dec_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dec_fire) begin
            out_sample_reg <= dec_sample;
            out_last_reg   <= phase_reg;
            out_end_reg    <= hdr_reg.end_bit;
            out_loop_reg   <= hdr_reg.loop_bit;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_sample    = out_sample_reg;
    assign m_last      = out_last_reg;
    assign m_end_flag  = out_end_reg;
    assign m_loop_flag = out_loop_reg;

endmodule

>>> tb/tb_brr_adpcm_block_decoder_core.sv
// Self-checking bench for brr_adpcm_block_decoder_core: directed table, then random BRR blocks.
// Predicts samples with its own nibble decoder and scoreboards every result beat in order.
// Depends on brr_pkg and the design sources only.
`timescale 1ns / 1ps

module tb_brr_adpcm_block_decoder_core
    import brr_pkg::*;
();

    localparam int N_ITEMS   = 1100;
    localparam int MAX_CYC   = 400000;
    localparam int HOLD_CYC  = 300;
    localparam int HOLD_AT   = 400;
    localparam int DRAIN_CYC = 8;
    localparam int N_ROWS    = 26;

    // One decoded result beat.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       end_flag;
        logic                       loop_flag;
    } smp_t;

    // One row of the directed table; hi/lo used only when typed is set.
    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              hdr;
        logic              typed;
        logic signed [15:0] hi;
        logic signed [15:0] lo;
    } row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [BYTE_W-1:0]          s_data_byte;
    logic                       s_is_header;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample;
    logic                       m_last;
    logic                       m_end_flag;
    logic                       m_loop_flag;

    // Predictor state.
    int   last_smp;
    int   older_smp;
    hdr_t cur_hdr;

    smp_t pending_samples[$];
    int   errors;
    int   cycles;
    int   bytes_taken;
    int   beats_seen;
    int   snd_run;
    int   rcv_run;
    bit   snd_calm;
    bit   rcv_calm;
    bit   held_off;

    row_t directed_rows [N_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 16'sd0,     16'sd0},      // data before any header
        '{8'h78, 1'b0, 1'b1, 16'sd3,     -16'sd4},
        '{8'hC0, 1'b1, 1'b0, 16'sd0,     16'sd0},      // shift 12, filter none
        '{8'h78, 1'b0, 1'b1, 16'sd14336, -16'sd16384},
        '{8'hD3, 1'b1, 1'b0, 16'sd0,     16'sd0},      // shift 13, end and loop
        '{8'h8F, 1'b0, 1'b1, -16'sd4096, -16'sd4096},
        '{8'h70, 1'b0, 1'b1, 16'sd0,     16'sd0},
        '{8'hE0, 1'b1, 1'b0, 16'sd0,     16'sd0},
        '{8'hF7, 1'b0, 1'b1, -16'sd4096, 16'sd0},
        '{8'hF0, 1'b1, 1'b0, 16'sd0,     16'sd0},
        '{8'h80, 1'b0, 1'b1, -16'sd4096, 16'sd0},
        '{8'hC4, 1'b1, 1'b0, 16'sd0,     16'sd0},      // filter one, runs into overflow
        '{8'h77, 1'b0, 1'b0, 16'sd0,     16'sd0},
        '{8'h77, 1'b0, 1'b0, 16'sd0,     16'sd0},
        '{8'hC8, 1'b1, 1'b0, 16'sd0,     16'sd0},
        '{8'h77, 1'b0, 1'b0, 16'sd0,     16'sd0},
        '{8'h88, 1'b0, 1'b0, 16'sd0,     16'sd0},
        '{8'hCC, 1'b1, 1'b0, 16'sd0,     16'sd0},
        '{8'h77, 1'b0, 1'b0, 16'sd0,     16'sd0},
        '{8'h88, 1'b0, 1'b0, 16'sd0,     16'sd0},
        '{8'h0E, 1'b1, 1'b0, 16'sd0,     16'sd0},      // loop only
        '{8'hFF, 1'b0, 1'b0, 16'sd0,     16'sd0},
        '{8'h01, 1'b1, 1'b0, 16'sd0,     16'sd0},      // end only
        '{8'h11, 1'b0, 1'b0, 16'sd0,     16'sd0},
        '{8'hFF, 1'b1, 1'b0, 16'sd0,     16'sd0},
        '{8'h00, 1'b0, 1'b0, 16'sd0,     16'sd0}
    };

    brr_adpcm_block_decoder_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_is_header (s_is_header),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample    (m_sample),
        .m_last      (m_last),
        .m_end_flag  (m_end_flag),
        .m_loop_flag (m_loop_flag)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Idle length for the next beat: alternate between calm runs and busy runs.
    function automatic int draw_wait(inout int run_left, inout bit calm);
        if (run_left == 0) begin
            calm     = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(10, 40);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] decode_nibble(logic [NIB_W-1:0] nib);
        int s;
        int p1;
        int p2;
        logic signed [SAMPLE_W-1:0] w;
        p1 = last_smp;
        p2 = older_smp;
        s  = int'(nib);
        if (s > 7) s -= 16;
        if (cur_hdr.shift <= SHIFT_MAX) begin
            s = (s <<< cur_hdr.shift) >>> 1;
        end else begin
            s = (s < 0) ? int'(LARGE_NEG) : 0;
        end
        case (cur_hdr.filter)
            FILT_ONE: begin
                s += p1 + ((-p1) >>> 4);
            end
            FILT_TWO: begin
                s += 2 * p1 + ((-3 * p1) >>> 5) - p2 + (p2 >>> 4);
            end
            FILT_THREE: begin
                s += 2 * p1 + ((-13 * p1) >>> 6) - p2 + ((3 * p2) >>> 4);
            end
            default: begin
            end
        endcase
        if (s < int'(SAMPLE_MIN)) s = int'(SAMPLE_MIN);
        if (s > int'(SAMPLE_MAX)) s = int'(SAMPLE_MAX);
        // keep the low 15 bits as a signed value
        w         = s[SAMPLE_W-1:0];
        older_smp = last_smp;
        last_smp  = int'(w);
        return w;
    endfunction

    // Advance the predictor by one accepted byte and queue its samples.
    function automatic void take_byte(logic [BYTE_W-1:0] code, logic hdr, logic typed,
                                      int hi, int lo);
        smp_t e0;
        smp_t e1;
        if (hdr) begin
            cur_hdr = hdr_t'(code);
            return;
        end
        e0.sample = decode_nibble(code[7:4]);
        e1.sample = decode_nibble(code[3:0]);
        if (typed) begin
            e0.sample = SAMPLE_W'(hi);
            e1.sample = SAMPLE_W'(lo);
        end
        e0.last      = 1'b0;
        e1.last      = 1'b1;
        e0.end_flag  = cur_hdr.end_bit;
        e1.end_flag  = cur_hdr.end_bit;
        e0.loop_flag = cur_hdr.loop_bit;
        e1.loop_flag = cur_hdr.loop_bit;
        pending_samples.push_back(e0);
        pending_samples.push_back(e1);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s at result beat %0d: got %0d, want %0d",
                 what, beats_seen, got, want);
    endtask

    task automatic send_beat(logic [BYTE_W-1:0] code, logic hdr, logic typed, int hi, int lo);
        int gap;
        gap = draw_wait(snd_run, snd_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data_byte <= code;
        s_is_header <= hdr;
        s_valid     <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        take_byte(code, hdr, typed, hi, lo);
        bytes_taken++;
    endtask

    function automatic logic [BYTE_W-1:0] rand_data();
        case ($urandom_range(0, 7))
            0: return 8'h77;
            1: return 8'h88;
            2: return BYTE_W'($urandom_range(0, 15) * 17);
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Result checker: compare every accepted beat with the oldest prediction.
    always @(posedge aclk) begin
        smp_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected beat, sample", int'(m_sample), 0);
            end else begin
                e = pending_samples.pop_front();
                if (m_sample !== e.sample)
                    report_mismatch("sample", int'(m_sample), int'(e.sample));
                if (m_last !== e.last)
                    report_mismatch("last", int'(m_last), int'(e.last));
                if (m_end_flag !== e.end_flag)
                    report_mismatch("end_flag", int'(m_end_flag), int'(e.end_flag));
                if (m_loop_flag !== e.loop_flag)
                    report_mismatch("loop_flag", int'(m_loop_flag), int'(e.loop_flag));
            end
            beats_seen++;
        end
    end

    // Result side: random back-pressure, plus one long hold to fill the block.
    initial begin
        int w;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            w = draw_wait(rcv_run, rcv_calm);
            if (!held_off && bytes_taken >= HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge aclk);
                held_off = 1'b1;
            end else if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        int kind;
        int n;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_is_header = 1'b0;
        m_ready     = 1'b0;
        last_smp    = 0;
        older_smp   = 0;
        cur_hdr     = '0;
        errors      = 0;
        cycles      = 0;
        bytes_taken = 0;
        beats_seen  = 0;
        snd_run     = 0;
        rcv_run     = 0;
        snd_calm    = 1'b0;
        rcv_calm    = 1'b0;
        held_off    = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].code, directed_rows[i].hdr, directed_rows[i].typed,
                      int'(directed_rows[i].hi), int'(directed_rows[i].lo));

        while (bytes_taken < N_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                // well-formed block: header then eight data bytes
                send_beat(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0, 0, 0);
                repeat (8) send_beat(rand_data(), 1'b0, 1'b0, 0, 0);
            end else if (kind == 8) begin
                // truncated block
                n = $urandom_range(0, 7);
                send_beat(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0, 0, 0);
                repeat (n) send_beat(rand_data(), 1'b0, 1'b0, 0, 0);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_beat(BYTE_W'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1)), 1'b0, 0, 0);
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (errors == 0 && pending_samples.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
